// File: design/bra_pkg.sv
`timescale 1ns / 1ps

package bra_pkg;

	// bitmap word geometry
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	// run lengths saturate at the largest count a request can carry
	localparam int CNT_W = 9;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_PROBE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [8:0] slot_count;
		logic [7:0] start_slot;
	} bra_in_t;

	typedef struct packed {
		logic [8:0] run_start;
		logic [1:0] status;
	} bra_out_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] bit_idx;
		logic [CNT_W-1:0] carry;
	} bra_scan_t;

endpackage

// File: design/bra_map_mem.sv
`timescale 1ns / 1ps

module bra_map_mem
	import bra_pkg::*;
#(
	parameter int WORDS = 8,
	parameter int AW    = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem_q [WORDS];
	logic [WORDS-1:0]  vld_q;
	logic [WORD_W-1:0] rd_word_s1;
	logic              rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_s1 <= mem_q[rd_addr];
		end
	end

	// a word never written reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? rd_word_s1 : '0;

endmodule

// File: design/bra_word_scan.sv
`timescale 1ns / 1ps

module bra_word_scan
	import bra_pkg::*;
(
	input  logic [WORD_W-1:0] used_word,
	input  logic [WORD_W-1:0] range_mask,
	input  logic [CNT_W-1:0]  carry_in,
	input  logic [CNT_W-1:0]  run_len,
	output bra_scan_t         scan
);

	logic [WORD_W-1:0] blk;
	logic [WORD_W-1:0] seen;
	logic [BIT_W-1:0]  last_blk [WORD_W];
	logic [CNT_W:0]    ext_sum [WORD_W];
	logic [CNT_W-1:0]  run_end [WORD_W];
	logic [WORD_W-1:0] hit;

	// slots outside the pass count as used so runs break there
	assign blk = used_word | ~range_mask;

	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			seen[j]     = 1'b0;
			last_blk[j] = '0;
			for (int k = 0; k < WORD_W; k++) begin
				if (k < j && blk[k]) begin
					seen[j]     = 1'b1;
					last_blk[j] = BIT_W'(k);
				end
			end
			ext_sum[j] = {1'b0, carry_in} + (CNT_W + 1)'(j + 1);
			if (blk[j]) begin
				run_end[j] = '0;
			end else if (seen[j]) begin
				run_end[j] = CNT_W'(BIT_W'(j) - last_blk[j]);
			end else if (ext_sum[j][CNT_W]) begin
				run_end[j] = '1;
			end else begin
				run_end[j] = ext_sum[j][CNT_W-1:0];
			end
			hit[j] = !blk[j] && (run_end[j] >= run_len);
		end
	end

	always_comb begin
		scan.found   = |hit;
		scan.bit_idx = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (hit[j]) begin
				scan.bit_idx = BIT_W'(j);
			end
		end
		scan.carry = run_end[WORD_W-1];
	end

endmodule

// File: design/bitmap_run_allocator_core.sv
`timescale 1ns / 1ps
// channel   direction  handshake                payload
// in        input      in_valid / in_ready      in_data   (bra_in_t)
// out       output     out_valid / out_ready    out_data  (bra_out_t)
//
// Allocate/probe: bitmap words are scanned from the rover word to the last word, then
// from word 0 up to the rover word (up to words+1, the rover word is seen in both
// passes); allocate then marks the run, reading and writing each word it covers.
// Free: every slot of the run is checked used, word by word, then the words cleared;
// requests decided at once go straight to the result. One item at a time.
// Reset clears the map through per-word valid bits; no clearing pass is needed.
// A result waits in the output register while the next word is accepted; a full
// output register keeps the next result waiting and blocks the input.

module bitmap_run_allocator_core
	import bra_pkg::*;
#(
	parameter int MAP_SLOTS = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  bra_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output bra_out_t out_data
);

	localparam int WORDS  = (MAP_SLOTS + WORD_W - 1) / WORD_W;
	localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SLOT_W = $clog2(MAP_SLOTS + 1);
	localparam int XW     = (SLOT_W > 10) ? SLOT_W : 10;
	localparam logic [XW-1:0] MAP_X     = XW'(MAP_SLOTS);
	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MRD,
		S_MWR,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] rover_q;
	logic [1:0]        op_q;
	logic [CNT_W-1:0]  len_q;
	logic              pass_q;
	logic              issue_q;
	logic              first_q;
	logic [AW-1:0]     waddr_q;
	logic [AW-1:0]     wend_q;
	logic              pend_s1;
	logic [AW-1:0]     widx_s1;
	logic              wpass_s1;
	logic              first_s1;
	logic              last_s1;
	logic [CNT_W-1:0]  carry_q;
	logic [XW-1:0]     mlo_q;
	logic [XW-1:0]     mend_q;
	logic              verify_q;
	bra_out_t          res_q;
	logic              out_valid_q;
	bra_out_t          out_data_q;

	logic              mem_rd_en;
	logic [WORD_W-1:0] mem_rd_data;
	logic              mem_wr_en;
	logic [WORD_W-1:0] mem_wr_data;

	logic [XW-1:0]     rover_x;
	logic [XW-1:0]     len_x;
	logic [XW-1:0]     cnt_in_x;
	logic [XW-1:0]     start_in_x;
	logic [XW-1:0]     free_end_x;
	logic [AW-1:0]     mask_word;
	logic [XW-1:0]     mask_lo;
	logic [XW-1:0]     mask_hi;
	logic [XW-1:0]     mask_base;
	logic [WORD_W-1:0] range_mask;
	logic [CNT_W-1:0]  carry_in;
	bra_scan_t         scan;
	logic [XW-1:0]     end_x;
	logic [XW-1:0]     found_x;
	logic              in_fire;
	logic              pass_turn;

	assign rover_x    = XW'(rover_q);
	assign len_x      = XW'(len_q);
	assign cnt_in_x   = XW'(in_data.slot_count);
	assign start_in_x = XW'(in_data.start_slot);
	assign free_end_x = start_in_x + cnt_in_x;
	assign in_fire    = in_valid && in_ready;
	assign in_ready   = (state_q == S_IDLE);

	// second pass follows the first unless the rover sits at slot 0
	assign pass_turn = !pass_q && (rover_q != '0);

	// window of slots that count for the word in hand
	always_comb begin
		if (state_q == S_SCAN) begin
			mask_word = widx_s1;
			mask_lo   = wpass_s1 ? '0 : rover_x;
			mask_hi   = wpass_s1 ? rover_x : MAP_X;
		end else begin
			mask_word = waddr_q;
			mask_lo   = mlo_q;
			mask_hi   = mend_q;
		end
		mask_base = XW'(mask_word) << BIT_W;
		for (int k = 0; k < WORD_W; k++) begin
			range_mask[k] = ((mask_base + XW'(k)) >= mask_lo) &&
				((mask_base + XW'(k)) < mask_hi);
		end
	end

	assign carry_in = first_s1 ? '0 : carry_q;
	assign end_x    = (XW'(widx_s1) << BIT_W) | XW'(scan.bit_idx);
	assign found_x  = end_x + XW'(1) - len_x;

	// reads and writes never share a cycle: a modify is always read then written
	assign mem_rd_en   = ((state_q == S_SCAN) && issue_q) || (state_q == S_MRD);
	assign mem_wr_en   = (state_q == S_MWR) && !verify_q;
	assign mem_wr_data = (op_q == OP_ALLOC) ? (mem_rd_data | range_mask)
		: (mem_rd_data & ~range_mask);

	bra_map_mem #(
		.WORDS (WORDS),
		.AW    (AW)
	) u_map_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (waddr_q),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (waddr_q),
		.wr_data (mem_wr_data)
	);

	bra_word_scan u_word_scan (
		.used_word  (mem_rd_data),
		.range_mask (range_mask),
		.carry_in   (carry_in),
		.run_len    (len_q),
		.scan       (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rover_q     <= '0;
			op_q        <= OP_ALLOC;
			len_q       <= '0;
			pass_q      <= 1'b0;
			issue_q     <= 1'b0;
			first_q     <= 1'b0;
			waddr_q     <= '0;
			wend_q      <= '0;
			pend_s1     <= 1'b0;
			widx_s1     <= '0;
			wpass_s1    <= 1'b0;
			first_s1    <= 1'b0;
			last_s1     <= 1'b0;
			carry_q     <= '0;
			mlo_q       <= '0;
			mend_q      <= '0;
			verify_q    <= 1'b0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			pend_s1 <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						op_q  <= in_data.opcode;
						len_q <= in_data.slot_count;
						unique case (in_data.opcode) inside
							OP_ALLOC, OP_PROBE: begin
								if (cnt_in_x == '0 || cnt_in_x > MAP_X) begin
									res_q.run_start <= MAP_X[8:0];
									res_q.status    <= ST_NOSPACE;
									state_q         <= S_DONE;
								end else begin
									issue_q <= 1'b1;
									first_q <= 1'b1;
									state_q <= S_SCAN;
									if (rover_x != MAP_X) begin
										pass_q  <= 1'b0;
										waddr_q <= AW'(rover_x >> BIT_W);
										wend_q  <= LAST_WORD;
									end else begin
										pass_q  <= 1'b1;
										waddr_q <= '0;
										wend_q  <= AW'((rover_x - XW'(1)) >> BIT_W);
									end
								end
							end
							OP_FREE: begin
								res_q.run_start <= 9'(in_data.start_slot);
								if (start_in_x >= MAP_X || cnt_in_x > MAP_X - start_in_x) begin
									res_q.status <= ST_BADFREE;
									state_q      <= S_DONE;
								end else if (cnt_in_x == '0) begin
									rover_q      <= SLOT_W'(start_in_x);
									res_q.status <= ST_OK;
									state_q      <= S_DONE;
								end else begin
									mlo_q    <= start_in_x;
									mend_q   <= free_end_x;
									waddr_q  <= AW'(start_in_x >> BIT_W);
									wend_q   <= AW'((free_end_x - XW'(1)) >> BIT_W);
									verify_q <= 1'b1;
									state_q  <= S_MRD;
								end
							end
							default: begin
								res_q.run_start <= '0;
								res_q.status    <= ST_BADFREE;
								state_q         <= S_DONE;
							end
						endcase
					end
				end

				S_SCAN: begin
					// issue side: one word read per cycle
					if (issue_q) begin
						pend_s1  <= 1'b1;
						widx_s1  <= waddr_q;
						wpass_s1 <= pass_q;
						first_s1 <= first_q;
						last_s1  <= (waddr_q == wend_q) && !pass_turn;
						if (waddr_q == wend_q) begin
							if (pass_turn) begin
								pass_q  <= 1'b1;
								waddr_q <= '0;
								wend_q  <= AW'((rover_x - XW'(1)) >> BIT_W);
								first_q <= 1'b1;
							end else begin
								issue_q <= 1'b0;
							end
						end else begin
							waddr_q <= waddr_q + AW'(1);
							first_q <= 1'b0;
						end
					end
					// check side: word read in the previous cycle
					if (pend_s1) begin
						carry_q <= scan.carry;
						if (scan.found) begin
							issue_q         <= 1'b0;
							pend_s1         <= 1'b0;
							res_q.run_start <= found_x[8:0];
							res_q.status    <= ST_OK;
							if (op_q == OP_ALLOC) begin
								rover_q  <= SLOT_W'(end_x + XW'(1));
								mlo_q    <= found_x;
								mend_q   <= end_x + XW'(1);
								waddr_q  <= AW'(found_x >> BIT_W);
								wend_q   <= AW'(end_x >> BIT_W);
								verify_q <= 1'b0;
								state_q  <= S_MRD;
							end else begin
								state_q <= S_DONE;
							end
						end else if (last_s1) begin
							issue_q         <= 1'b0;
							pend_s1         <= 1'b0;
							res_q.run_start <= MAP_X[8:0];
							res_q.status    <= ST_NOSPACE;
							state_q         <= S_DONE;
						end
					end
				end

				S_MRD: begin
					state_q <= S_MWR;
				end

				S_MWR: begin
					if (verify_q) begin
						if ((mem_rd_data & range_mask) != range_mask) begin
							res_q.status <= ST_BADFREE;
							state_q      <= S_DONE;
						end else if (waddr_q == wend_q) begin
							// every slot checked used: go back and clear
							verify_q <= 1'b0;
							waddr_q  <= AW'(mlo_q >> BIT_W);
							state_q  <= S_MRD;
						end else begin
							waddr_q <= waddr_q + AW'(1);
							state_q <= S_MRD;
						end
					end else if (waddr_q == wend_q) begin
						if (op_q == OP_FREE) begin
							rover_q <= SLOT_W'(mlo_q);
						end
						res_q.status <= ST_OK;
						state_q      <= S_DONE;
					end else begin
						waddr_q <= waddr_q + AW'(1);
						state_q <= S_MRD;
					end
				end

				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_data_q  <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_rover_range: assert property (@(posedge clk) disable iff (!arst_n)
		rover_q <= SLOT_W'(MAP_SLOTS))
		else $error("rover beyond map");

	a_item_taken: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("accepted word not processed");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result loaded outside completion");

	a_port_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_rd_en && mem_wr_en))
		else $error("bitmap read and write in same cycle");

endmodule
